[rtl/core/tndc_pkg.sv]
// Shared types, constants and arithmetic helpers for the timer deadline pipeline.
package tndc_pkg;

    // Timer kinds as carried on the slave-side tuser.
    localparam logic [1:0] KIND_PRECISE     = 2'd0;
    localparam logic [1:0] KIND_COARSE      = 2'd1;
    localparam logic [1:0] KIND_VERY_COARSE = 2'd2;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [19:0] NS_PER_MS  = 20'd1000000;
    localparam logic [9:0]  MS_PER_SEC = 10'd1000;

    // Reciprocals for constant division, each exact over its operand width.
    // (x >> 3) * DIV1000_MUL >> 35 gives x / 1000 for a 31-bit x.
    localparam logic [28:0] DIV1000_MUL = 29'd274877907;
    // (x >> 6) * DIV1E6_MUL >> 38 gives x / 1000000 for a 30-bit x.
    localparam logic [24:0] DIV1E6_MUL  = 25'd17592187;
    // (x >> 2) * DIV5_MUL >> 16 gives x / 20 for x below 20480.
    localparam logic [13:0] DIV5_MUL    = 14'd13108;

    typedef enum logic [1:0] {
        MODE_EVEN,
        MODE_QUAD,
        MODE_EDGE,
        MODE_STEP
    } mode_t;

    typedef enum logic [2:0] {
        STEP_25,
        STEP_50,
        STEP_100,
        STEP_200,
        STEP_250,
        STEP_500
    } step_t;

    typedef struct packed {
        logic [31:0] sec;
        logic [29:0] nsec;
    } tstamp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] iv;
        tstamp_t     dl;
        tstamp_t     now;
        logic [21:0] q;
        logic [29:0] rns;
        logic [9:0]  slack;
        logic [31:0] vc_sec;
        mode_t       mode;
        step_t       step;
    } prep_t;

    typedef struct packed {
        prep_t   ctx;
        tstamp_t dl1;
    } adv_t;

    // Carries one second out of a nanosecond count below two seconds.
    function automatic tstamp_t norm_time(input logic [31:0] sec, input logic [30:0] nsec);
        tstamp_t t;
        if (nsec >= 31'(NS_PER_SEC)) begin
            t.sec  = sec + 32'd1;
            t.nsec = 30'(nsec - 31'(NS_PER_SEC));
        end else begin
            t.sec  = sec;
            t.nsec = nsec[29:0];
        end
        return t;
    endfunction

    function automatic logic time_before(input tstamp_t a, input tstamp_t b);
        return (a.sec < b.sec) || ((a.sec == b.sec) && (a.nsec < b.nsec));
    endfunction

    // Largest multiple of step not above v; step is always a constant at the call.
    function automatic logic [9:0] floor_mult(input logic [9:0] v, input logic [9:0] step);
        logic [9:0] b;
        b = '0;
        for (int k = 1; k <= 40; k++) begin
            if (k * int'(step) <= int'(v)) begin
                b = 10'(k * int'(step));
            end
        end
        return b;
    endfunction

endpackage

[rtl/core/tndc_prep.sv]
// Front stages: time normalization, interval split into seconds and milliseconds, rounding class.
module tndc_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [1:0]        kind,
    input  logic [30:0]       interval,
    input  logic [31:0]       deadline_sec,
    input  logic [29:0]       deadline_nsec,
    input  logic [31:0]       now_sec,
    input  logic [29:0]       now_nsec,
    output logic              out_valid,
    output tndc_pkg::prep_t   out_item
);

    // Stage 1
    logic                s1_valid_reg;
    logic [1:0]          s1_kind_reg;
    logic [30:0]         s1_iv_reg;
    tndc_pkg::tstamp_t   s1_dl_reg, s1_dl_next;
    tndc_pkg::tstamp_t   s1_now_reg, s1_now_next;
    logic [21:0]         s1_q_reg, s1_q_next;
    logic [9:0]          s1_slack_reg, s1_slack_next;
    logic [56:0]         prod1000;
    logic [26:0]         prod5;

    // Stage 2
    logic                s2_valid_reg;
    logic [1:0]          s2_kind_reg;
    logic [30:0]         s2_iv_reg;
    tndc_pkg::tstamp_t   s2_dl_reg, s2_now_reg;
    logic [21:0]         s2_q_reg;
    logic [9:0]          s2_slack_reg;
    logic [9:0]          s2_r_reg, s2_r_next;
    logic [31:0]         s2_vc_reg, s2_vc_next;
    logic                s2_small_reg, s2_small_next;
    logic                s2_lt50_reg, s2_lt50_next;
    logic                s2_ge5000_reg, s2_ge5000_next;
    logic [31:0]         rem_full;
    logic [31:0]         vc_sum;

    // Stage 3
    logic                s3_valid_reg;
    tndc_pkg::prep_t     s3_item_reg, s3_item_next;
    logic                m500, m50, m100, m200, m250;

    always_comb
    begin
        s1_dl_next  = tndc_pkg::norm_time(deadline_sec, {1'b0, deadline_nsec});
        s1_now_next = tndc_pkg::norm_time(now_sec, {1'b0, now_nsec});
        prod1000    = 57'(interval[30:3]) * 57'(tndc_pkg::DIV1000_MUL);
        s1_q_next   = prod1000[56:35];
        prod5       = 27'(interval[14:2]) * 27'(tndc_pkg::DIV5_MUL);
        // The allowed error never needs to exceed a whole second.
        if (interval >= 31'd20000) begin
            s1_slack_next = tndc_pkg::MS_PER_SEC;
        end else begin
            s1_slack_next = prod5[25:16];
        end
    end

    always_comb
    begin
        rem_full  = 32'(s1_iv_reg) - 32'(s1_q_reg) * 32'd1000;
        s2_r_next = rem_full[9:0];
        vc_sum    = s1_dl_reg.sec + 32'(s1_iv_reg);
        if (vc_sum <= s1_now_reg.sec) begin
            s2_vc_next = s1_now_reg.sec + 32'(s1_iv_reg);
        end else begin
            s2_vc_next = vc_sum;
        end
        s2_small_next  = (s1_iv_reg < 31'd100) && (s1_iv_reg != 31'd25)
                         && (s1_iv_reg != 31'd50) && (s1_iv_reg != 31'd75);
        s2_lt50_next   = s1_iv_reg < 31'd50;
        s2_ge5000_next = s1_iv_reg >= 31'd5000;
    end

    // Every step size divides 1000, so the millisecond remainder decides divisibility.
    always_comb
    begin
        m500 = (s2_r_reg == 10'd0) || (s2_r_reg == 10'd500);
        m50  = tndc_pkg::floor_mult(s2_r_reg, 10'd50) == s2_r_reg;
        m100 = tndc_pkg::floor_mult(s2_r_reg, 10'd100) == s2_r_reg;
        m200 = tndc_pkg::floor_mult(s2_r_reg, 10'd200) == s2_r_reg;
        m250 = tndc_pkg::floor_mult(s2_r_reg, 10'd250) == s2_r_reg;

        s3_item_next.kind   = s2_kind_reg;
        s3_item_next.iv     = s2_iv_reg;
        s3_item_next.dl     = s2_dl_reg;
        s3_item_next.now    = s2_now_reg;
        s3_item_next.q      = s2_q_reg;
        s3_item_next.rns    = 30'(30'(s2_r_reg) * 30'(tndc_pkg::NS_PER_MS));
        s3_item_next.slack  = s2_slack_reg;
        s3_item_next.vc_sec = s2_vc_reg;

        if (s2_small_reg) begin
            s3_item_next.mode = s2_lt50_reg ? tndc_pkg::MODE_EVEN : tndc_pkg::MODE_QUAD;
        end else if (m500 && s2_ge5000_reg) begin
            s3_item_next.mode = tndc_pkg::MODE_EDGE;
        end else begin
            s3_item_next.mode = tndc_pkg::MODE_STEP;
        end

        if (m500) begin
            s3_item_next.step = tndc_pkg::STEP_500;
        end else if (m200) begin
            s3_item_next.step = tndc_pkg::STEP_200;
        end else if (m100) begin
            s3_item_next.step = tndc_pkg::STEP_100;
        end else if (m250) begin
            s3_item_next.step = tndc_pkg::STEP_250;
        end else if (m50) begin
            s3_item_next.step = tndc_pkg::STEP_50;
        end else begin
            s3_item_next.step = tndc_pkg::STEP_25;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg    <= kind;
            s1_iv_reg      <= interval;
            s1_dl_reg      <= s1_dl_next;
            s1_now_reg     <= s1_now_next;
            s1_q_reg       <= s1_q_next;
            s1_slack_reg   <= s1_slack_next;

            s2_kind_reg    <= s1_kind_reg;
            s2_iv_reg      <= s1_iv_reg;
            s2_dl_reg      <= s1_dl_reg;
            s2_now_reg     <= s1_now_reg;
            s2_q_reg       <= s1_q_reg;
            s2_slack_reg   <= s1_slack_reg;
            s2_r_reg       <= s2_r_next;
            s2_vc_reg      <= s2_vc_next;
            s2_small_reg   <= s2_small_next;
            s2_lt50_reg    <= s2_lt50_next;
            s2_ge5000_reg  <= s2_ge5000_next;

            s3_item_reg    <= s3_item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

[rtl/core/tndc_advance.sv]
// Middle stages: adds the interval to the old deadline and to now, and keeps the one not in the past.
module tndc_advance (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tndc_pkg::prep_t   in_item,
    output logic              out_valid,
    output tndc_pkg::adv_t    out_item
);

    logic                a1_valid_reg;
    tndc_pkg::prep_t     a1_ctx_reg;
    logic [31:0]         a1_dsec_reg, a1_dsec_next;
    logic [30:0]         a1_dns_reg, a1_dns_next;
    logic [31:0]         a1_nsec_reg, a1_nsec_next;
    logic [30:0]         a1_nns_reg, a1_nns_next;

    logic                a2_valid_reg;
    tndc_pkg::prep_t     a2_ctx_reg;
    tndc_pkg::tstamp_t   a2_from_dl_reg, a2_from_dl_next;
    tndc_pkg::tstamp_t   a2_from_now_reg, a2_from_now_next;

    logic                a3_valid_reg;
    tndc_pkg::adv_t      a3_item_reg, a3_item_next;

    always_comb
    begin
        a1_dsec_next = in_item.dl.sec + 32'(in_item.q);
        a1_dns_next  = 31'(in_item.dl.nsec) + 31'(in_item.rns);
        a1_nsec_next = in_item.now.sec + 32'(in_item.q);
        a1_nns_next  = 31'(in_item.now.nsec) + 31'(in_item.rns);
    end

    always_comb
    begin
        a2_from_dl_next  = tndc_pkg::norm_time(a1_dsec_reg, a1_dns_reg);
        a2_from_now_next = tndc_pkg::norm_time(a1_nsec_reg, a1_nns_reg);
    end

    always_comb
    begin
        a3_item_next.ctx = a2_ctx_reg;
        if (tndc_pkg::time_before(a2_from_dl_reg, a2_ctx_reg.now)) begin
            a3_item_next.dl1 = a2_from_now_reg;
        end else begin
            a3_item_next.dl1 = a2_from_dl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
            a3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a1_valid_reg <= in_valid;
            a2_valid_reg <= a1_valid_reg;
            a3_valid_reg <= a2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_ctx_reg      <= in_item;
            a1_dsec_reg     <= a1_dsec_next;
            a1_dns_reg      <= a1_dns_next;
            a1_nsec_reg     <= a1_nsec_next;
            a1_nns_reg      <= a1_nns_next;

            a2_ctx_reg      <= a1_ctx_reg;
            a2_from_dl_reg  <= a2_from_dl_next;
            a2_from_now_reg <= a2_from_now_next;

            a3_item_reg     <= a3_item_next;
        end
    end

    assign out_valid = a3_valid_reg;
    assign out_item  = a3_item_reg;

endmodule

[rtl/core/tndc_snap.sv]
// Back stages: millisecond snapping for coarse timers, late catch-up, kind select and output register.
module tndc_snap (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  tndc_pkg::adv_t      in_item,
    output logic                out_valid,
    output tndc_pkg::tstamp_t   out_time
);

    // T1: milliseconds of the advanced deadline
    logic                t1_valid_reg;
    tndc_pkg::adv_t      t1_adv_reg;
    logic [9:0]          t1_ms_reg, t1_ms_next;
    logic [48:0]         prod_ms;

    // T2: reachable window and candidate boundaries
    logic                t2_valid_reg;
    tndc_pkg::adv_t      t2_adv_reg;
    logic [9:0]          t2_ms_reg;
    logic [9:0]          t2_lo_reg, t2_lo_next;
    logic [9:0]          t2_hi_reg, t2_hi_next;
    logic [9:0]          t2_base_reg, t2_base_next;
    logic [9:0]          t2_step_reg, t2_step_next;
    logic [9:0]          t2_small_reg, t2_small_next;
    logic [10:0]         hi_sum;
    logic [9:0]          b25, b50, b100, b200, b250, b500;
    logic                up50, up100;

    // T3: snapped fraction
    logic                t3_valid_reg;
    tndc_pkg::adv_t      t3_adv_reg;
    logic [9:0]          t3_frac_reg, t3_frac_next;
    logic [10:0]         mid, upper;

    // T4: snapped deadline
    logic                t4_valid_reg;
    tndc_pkg::adv_t      t4_adv_reg;
    tndc_pkg::tstamp_t   t4_dl2_reg, t4_dl2_next;

    // T5: one more interval, raw sums
    logic                t5_valid_reg;
    tndc_pkg::adv_t      t5_adv_reg;
    tndc_pkg::tstamp_t   t5_dl2_reg;
    logic [31:0]         t5_sec_reg, t5_sec_next;
    logic [30:0]         t5_nsec_reg, t5_nsec_next;
    logic                t5_late_reg, t5_late_next;

    // T6: normalized catch-up deadline
    logic                t6_valid_reg;
    tndc_pkg::adv_t      t6_adv_reg;
    tndc_pkg::tstamp_t   t6_dl2_reg;
    logic                t6_late_reg;
    tndc_pkg::tstamp_t   t6_redo_reg, t6_redo_next;

    // Output register
    logic                out_valid_reg;
    tndc_pkg::tstamp_t   out_time_reg, out_time_next;

    always_comb
    begin
        prod_ms    = 49'(in_item.dl1.nsec[29:6]) * 49'(tndc_pkg::DIV1E6_MUL);
        t1_ms_next = prod_ms[47:38];
    end

    always_comb
    begin
        if (t1_ms_reg >= t1_adv_reg.ctx.slack) begin
            t2_lo_next = t1_ms_reg - t1_adv_reg.ctx.slack;
        end else begin
            t2_lo_next = '0;
        end
        hi_sum = 11'(t1_ms_reg) + 11'(t1_adv_reg.ctx.slack);
        if (hi_sum > 11'(tndc_pkg::MS_PER_SEC)) begin
            t2_hi_next = tndc_pkg::MS_PER_SEC;
        end else begin
            t2_hi_next = hi_sum[9:0];
        end

        b25  = tndc_pkg::floor_mult(t1_ms_reg, 10'd25);
        b50  = tndc_pkg::floor_mult(t1_ms_reg, 10'd50);
        b100 = tndc_pkg::floor_mult(t1_ms_reg, 10'd100);
        b200 = tndc_pkg::floor_mult(t1_ms_reg, 10'd200);
        b250 = tndc_pkg::floor_mult(t1_ms_reg, 10'd250);
        b500 = tndc_pkg::floor_mult(t1_ms_reg, 10'd500);

        unique case (t1_adv_reg.ctx.step)
            tndc_pkg::STEP_50:  begin t2_base_next = b50;  t2_step_next = 10'd50;  end
            tndc_pkg::STEP_100: begin t2_base_next = b100; t2_step_next = 10'd100; end
            tndc_pkg::STEP_200: begin t2_base_next = b200; t2_step_next = 10'd200; end
            tndc_pkg::STEP_250: begin t2_base_next = b250; t2_step_next = 10'd250; end
            tndc_pkg::STEP_500: begin t2_base_next = b500; t2_step_next = 10'd500; end
            default:            begin t2_base_next = b25;  t2_step_next = 10'd25;  end
        endcase

        // Short intervals set a low bit rather than rounding by addition.
        up50  = (t1_ms_reg - b50) >= 10'd25;
        up100 = (t1_ms_reg - b100) >= 10'd50;
        if (t1_adv_reg.ctx.mode == tndc_pkg::MODE_EVEN) begin
            t2_small_next = {t1_ms_reg[9:2], t1_ms_reg[1] | up50, 1'b0};
        end else begin
            t2_small_next = {t1_ms_reg[9:3], t1_ms_reg[2] | up100, 2'b00};
        end
    end

    always_comb
    begin
        mid   = 11'(t2_base_reg) + 11'(t2_step_reg >> 1);
        upper = 11'(t2_base_reg) + 11'(t2_step_reg);
        case (t2_adv_reg.ctx.mode) inside
            tndc_pkg::MODE_EVEN, tndc_pkg::MODE_QUAD:
            begin
                t3_frac_next = t2_small_reg;
            end
            default:
            begin
                if (t2_lo_reg == 10'd0) begin
                    t3_frac_next = '0;
                end else if (t2_hi_reg == tndc_pkg::MS_PER_SEC) begin
                    t3_frac_next = tndc_pkg::MS_PER_SEC;
                end else if (t2_adv_reg.ctx.mode == tndc_pkg::MODE_EDGE) begin
                    t3_frac_next = (t2_ms_reg >= 10'd500) ? t2_hi_reg : t2_lo_reg;
                end else if (11'(t2_ms_reg) < mid) begin
                    t3_frac_next = (t2_base_reg > t2_lo_reg) ? t2_base_reg : t2_lo_reg;
                end else if (upper < 11'(t2_hi_reg)) begin
                    t3_frac_next = upper[9:0];
                end else begin
                    t3_frac_next = t2_hi_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        if (t3_frac_reg == tndc_pkg::MS_PER_SEC) begin
            t4_dl2_next.sec  = t3_adv_reg.dl1.sec + 32'd1;
            t4_dl2_next.nsec = '0;
        end else begin
            t4_dl2_next.sec  = t3_adv_reg.dl1.sec;
            t4_dl2_next.nsec = 30'(30'(t3_frac_reg) * 30'(tndc_pkg::NS_PER_MS));
        end
    end

    always_comb
    begin
        t5_sec_next  = t4_dl2_reg.sec + 32'(t4_adv_reg.ctx.q);
        t5_nsec_next = 31'(t4_dl2_reg.nsec) + 31'(t4_adv_reg.ctx.rns);
        t5_late_next = tndc_pkg::time_before(t4_dl2_reg, t4_adv_reg.ctx.now);
    end

    always_comb
    begin
        t6_redo_next = tndc_pkg::norm_time(t5_sec_reg, t5_nsec_reg);
    end

    always_comb
    begin
        unique case (t6_adv_reg.ctx.kind)
            tndc_pkg::KIND_PRECISE:
            begin
                out_time_next = t6_adv_reg.dl1;
            end
            tndc_pkg::KIND_COARSE:
            begin
                out_time_next = t6_late_reg ? t6_redo_reg : t6_dl2_reg;
            end
            tndc_pkg::KIND_VERY_COARSE:
            begin
                out_time_next.sec  = t6_adv_reg.ctx.vc_sec;
                out_time_next.nsec = t6_adv_reg.ctx.dl.nsec;
            end
            default:
            begin
                out_time_next = t6_adv_reg.ctx.dl;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            t4_valid_reg  <= 1'b0;
            t5_valid_reg  <= 1'b0;
            t6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg  <= in_valid;
            t2_valid_reg  <= t1_valid_reg;
            t3_valid_reg  <= t2_valid_reg;
            t4_valid_reg  <= t3_valid_reg;
            t5_valid_reg  <= t4_valid_reg;
            t6_valid_reg  <= t5_valid_reg;
            out_valid_reg <= t6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_adv_reg   <= in_item;
            t1_ms_reg    <= t1_ms_next;

            t2_adv_reg   <= t1_adv_reg;
            t2_ms_reg    <= t1_ms_reg;
            t2_lo_reg    <= t2_lo_next;
            t2_hi_reg    <= t2_hi_next;
            t2_base_reg  <= t2_base_next;
            t2_step_reg  <= t2_step_next;
            t2_small_reg <= t2_small_next;

            t3_adv_reg   <= t2_adv_reg;
            t3_frac_reg  <= t3_frac_next;

            t4_adv_reg   <= t3_adv_reg;
            t4_dl2_reg   <= t4_dl2_next;

            t5_adv_reg   <= t4_adv_reg;
            t5_dl2_reg   <= t4_dl2_reg;
            t5_sec_reg   <= t5_sec_next;
            t5_nsec_reg  <= t5_nsec_next;
            t5_late_reg  <= t5_late_next;

            t6_adv_reg   <= t5_adv_reg;
            t6_dl2_reg   <= t5_dl2_reg;
            t6_late_reg  <= t5_late_reg;
            t6_redo_reg  <= t6_redo_next;

            out_time_reg <= out_time_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_time  = out_time_reg;

endmodule

[rtl/core/timer_next_deadline_coarsening.sv]
// Top level of the periodic timer next-deadline calculator with coarsening.
//
// Each request on the slave-side stream carries one timer: its kind on tuser
// (precise, coarse or very coarse), its interval, its old deadline and the
// current time, both as 32-bit seconds plus nanoseconds. The master-side
// stream returns exactly one response per request, in order: the next
// deadline as seconds (wrapping at 32 bits) and nanoseconds.
//
// The datapath is a thirteen-stage pipeline with a global advance enable:
// three stages normalize the times and split the interval into seconds and
// milliseconds, three add the interval and pick the deadline that is not in
// the past, and seven snap coarse deadlines to a preferred millisecond
// boundary, add a catch-up interval when needed and select by timer kind.
// With no stall, one request is taken every cycle.
//
// Reset clears all stage valid bits; the pipeline is then empty and ready.
// When the receiver holds tready low with a response waiting, every stage
// freezes and s_axis_tready drops in the same cycle, so nothing is lost or
// repeated; the pipeline resumes in the cycle tready returns.
module timer_next_deadline_coarsening (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // From bit 0: interval[30:0], deadline_sec[31:0], deadline_nsec[29:0],
    // now_sec[31:0], now_nsec[29:0], zero padding.
    input  logic [159:0] s_axis_tdata,
    // From bit 0: timer_kind[1:0].
    input  logic [1:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // From bit 0: next_sec[31:0], next_nsec[29:0], zero padding.
    output logic [63:0]  m_axis_tdata
);

    logic                en;
    logic                prep_valid;
    tndc_pkg::prep_t     prep_out;
    logic                adv_valid;
    tndc_pkg::adv_t      adv_out;
    tndc_pkg::tstamp_t   next_time;

    // The whole pipeline moves unless a finished response is held by the receiver.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    tndc_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_axis_tvalid),
        .kind          (s_axis_tuser),
        .interval      (s_axis_tdata[30:0]),
        .deadline_sec  (s_axis_tdata[62:31]),
        .deadline_nsec (s_axis_tdata[92:63]),
        .now_sec       (s_axis_tdata[124:93]),
        .now_nsec      (s_axis_tdata[154:125]),
        .out_valid     (prep_valid),
        .out_item      (prep_out)
    );

    tndc_advance u_advance (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_item   (prep_out),
        .out_valid (adv_valid),
        .out_item  (adv_out)
    );

    tndc_snap u_snap (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (adv_valid),
        .in_item   (adv_out),
        .out_valid (m_axis_tvalid),
        .out_time  (next_time)
    );

    assign m_axis_tdata = {2'b00, next_time.nsec, next_time.sec};

    // A held response must freeze the inner stages as well.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(prep_valid) && $stable(adv_valid))
        else $error("pipeline stage moved during a stall");

    // The advanced deadline must already be carried into a valid nanosecond range.
    a_adv_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
        adv_valid |-> (adv_out.dl1.nsec < tndc_pkg::NS_PER_SEC)
                      && (adv_out.ctx.now.nsec < tndc_pkg::NS_PER_SEC))
        else $error("advanced deadline nanoseconds out of range");

    // Even rounding belongs only to intervals below 50 ms.
    a_even_class: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid && (prep_out.mode == tndc_pkg::MODE_EVEN) |-> prep_out.iv < 31'd50)
        else $error("even rounding chosen for a long interval");

    // The allowed error is clamped to one second.
    a_slack_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid |-> prep_out.slack <= tndc_pkg::MS_PER_SEC)
        else $error("rounding slack above one second");

    a_out_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> next_time.nsec < tndc_pkg::NS_PER_SEC)
        else $error("response nanoseconds out of range");

endmodule

[test/tb_top.sv]
// Self-checking stream testbench for the timer next-deadline calculator.
`timescale 1ns / 100ps

module tb_top;

    // The package names kinds 0 to 2; the fourth encoding is undefined and must pass through.
    localparam logic [1:0] KIND_UNDEFINED = 2'd3;

    localparam longint unsigned NSEC_IN_SEC = 64'd1000000000;
    localparam longint unsigned NSEC_IN_MS  = 64'd1000000;

    localparam int RANDOM_REQS   = 1550;
    localparam int DRAIN_EVERY   = 400;
    localparam int TAIL_CYCLES   = 40;
    localparam int REPORT_LIMIT  = 10;

    // Receiver back-pressure patterns, picked at random by the receiver process.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // One timer request as the driver sees it. The drain flag makes the driver
    // hold this request back until every outstanding deadline has come out.
    typedef struct {
        logic [1:0]  kind;
        logic [30:0] iv;
        logic [31:0] dl_sec;
        logic [29:0] dl_nsec;
        logic [31:0] now_sec;
        logic [29:0] now_nsec;
        bit          drain;
    } timer_req_t;

    // A point in time: seconds wrap at 32 bits, nanoseconds stay below one second.
    typedef struct packed {
        logic [31:0] sec;
        logic [29:0] nsec;
    } stamp_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;

    timer_req_t  pending_reqs[$];
    stamp_t      expected_deadlines[$];
    timer_req_t  cur_req;
    int          burst_left = 1;
    int          gap_left = 0;
    int          ready_cycle = 0;
    stall_mode_t ready_mode = STALL_NONE;
    int          kind_cnt[4] = '{0, 0, 0, 0};
    int          accepted_cnt = 0;
    int          checked_cnt = 0;
    int          error_cnt = 0;
    bit          load_next;

    timer_next_deadline_coarsening i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deadline arithmetic.
    // ------------------------------------------------------------------

    // Folds a nanosecond count below two seconds back into range, carrying
    // one second. Inputs of 10^9 or more nanoseconds get the same treatment.
    function automatic stamp_t carry_ns(longint unsigned s, longint unsigned ns);
        stamp_t t;
        if (ns >= NSEC_IN_SEC)
        begin
            t.sec  = 32'(s + 1);
            t.nsec = 30'(ns - NSEC_IN_SEC);
        end
        else
        begin
            t.sec  = 32'(s);
            t.nsec = 30'(ns);
        end
        return t;
    endfunction

    // Seconds compare as plain unsigned values after wrapping, then nanoseconds.
    function automatic bit is_earlier(stamp_t a, stamp_t b);
        return (a.sec < b.sec) || ((a.sec == b.sec) && (a.nsec < b.nsec));
    endfunction

    function automatic stamp_t add_millis(stamp_t t, longint unsigned ms);
        return carry_ns(t.sec + ms / 1000, t.nsec + (ms % 1000) * NSEC_IN_MS);
    endfunction

    // Moves the millisecond fraction of a coarse deadline to a preferred
    // boundary no further than interval/20 ms away (short intervals only set a low bit). A return of 1000 means
    // the next whole second.
    function automatic longint unsigned snap_ms(longint unsigned iv, longint unsigned ms);
        longint unsigned slack;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned step;
        longint unsigned base;
        longint unsigned mult;
        slack = iv / 20;
        // Short intervals only set a low bit: even below 50 ms, multiple of 4 above.
        if (iv < 100 && iv != 25 && iv != 50 && iv != 75)
        begin
            if (iv < 50)
                return ((ms >> 1) | ((ms % 50) >= 25)) << 1;
            return ((ms >> 2) | ((ms % 100) >= 50)) << 2;
        end
        lo = (ms >= slack) ? ms - slack : 0;
        hi = ms + slack;
        if (hi > 1000)
            hi = 1000;
        if (lo == 0)
            return 0;
        if (hi == 1000)
            return 1000;
        if (iv % 500 == 0)
        begin
            // Long half-second multiples go to whichever reachable end lies nearer a whole second.
            if (iv >= 5000)
                return (ms >= 500) ? hi : lo;
            step = 500;
        end
        else if (iv % 50 == 0)
        begin
            mult = iv / 50;
            if (mult % 4 == 0)
                step = 200;
            else if (mult % 2 == 0)
                step = 100;
            else if (mult % 5 == 0)
                step = 250;
            else
                step = 50;
        end
        else
        begin
            step = 25;
        end
        base = ms / step * step;
        if (ms < base + step / 2)
            return (base > lo) ? base : lo;
        return (base + step < hi) ? base + step : hi;
    endfunction

    // Next deadline for one request.
    function automatic stamp_t next_deadline(timer_req_t r);
        stamp_t          due;
        stamp_t          cur;
        longint unsigned ms;
        due = carry_ns(r.dl_sec, r.dl_nsec);
        cur = carry_ns(r.now_sec, r.now_nsec);
        case (r.kind)
            tndc_pkg::KIND_PRECISE, tndc_pkg::KIND_COARSE:
            begin
                due = add_millis(due, r.iv);
                // A timer that fell behind restarts from the current time.
                if (is_earlier(due, cur))
                    due = add_millis(cur, r.iv);
                if (r.kind == tndc_pkg::KIND_COARSE)
                begin
                    ms = snap_ms(r.iv, due.nsec / NSEC_IN_MS);
                    if (ms == 1000)
                        due = carry_ns(due.sec + 1, 0);
                    else
                        due.nsec = 30'(ms * NSEC_IN_MS);
                    // Snapping backwards may land in the past; catch up one interval.
                    if (is_earlier(due, cur))
                        due = add_millis(due, r.iv);
                end
            end
            tndc_pkg::KIND_VERY_COARSE:
            begin
                due.sec = 32'(due.sec + r.iv);
                if (due.sec <= cur.sec)
                    due.sec = 32'(cur.sec + r.iv);
            end
            default:
            begin
                // Undefined kind: the old deadline goes out after the nanosecond carry.
            end
        endcase
        return due;
    endfunction

    // ------------------------------------------------------------------
    // Request generation.
    // ------------------------------------------------------------------

    function automatic logic [159:0] pack_request(timer_req_t r);
        return {5'd0, r.now_nsec, r.now_sec, r.dl_nsec, r.dl_sec, r.iv};
    endfunction

    task automatic add_req(logic [1:0] kind, logic [30:0] iv, logic [31:0] ds,
                           logic [29:0] dn, logic [31:0] ns, logic [29:0] nn);
        timer_req_t r;
        r.kind     = kind;
        r.iv       = iv;
        r.dl_sec   = ds;
        r.dl_nsec  = dn;
        r.now_sec  = ns;
        r.now_nsec = nn;
        r.drain    = 1'b0;
        pending_reqs.push_back(r);
    endtask

    // Mostly realistic timers: the old deadline sits near the current time and
    // intervals favor the values the coarse rounding treats specially. About
    // one request in sixteen is raw noise over the full field ranges.
    function automatic timer_req_t build_random_req();
        timer_req_t r;
        int         pick;
        pick = $urandom_range(0, 15);
        r.drain = 1'b0;
        if (pick == 0)
        begin
            r.kind     = 2'($urandom_range(0, 3));
            r.iv       = 31'($urandom);
            r.dl_sec   = $urandom;
            r.dl_nsec  = 30'($urandom);
            r.now_sec  = $urandom;
            r.now_nsec = 30'($urandom);
            return r;
        end

        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.kind = KIND_UNDEFINED;
        else if (pick < 9)
            r.kind = tndc_pkg::KIND_COARSE;
        else if (pick < 15)
            r.kind = tndc_pkg::KIND_PRECISE;
        else
            r.kind = tndc_pkg::KIND_VERY_COARSE;

        if (r.kind == tndc_pkg::KIND_VERY_COARSE)
        begin
            r.iv = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 120));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: r.iv = 31'($urandom_range(0, 99));
                1:
                begin
                    case ($urandom_range(0, 5))
                        0: r.iv = 31'(25 * $urandom_range(1, 40));
                        1: r.iv = 31'(50 * $urandom_range(1, 40));
                        2: r.iv = 31'(100 * $urandom_range(1, 40));
                        3: r.iv = 31'(200 * $urandom_range(1, 40));
                        4: r.iv = 31'(250 * $urandom_range(1, 40));
                        default: r.iv = 31'(500 * $urandom_range(1, 40));
                    endcase
                end
                2: r.iv = 31'($urandom_range(100, 99999));
                3: r.iv = 31'(1000 * $urandom_range(1, 60));
                4: r.iv = 31'($urandom);
                default: r.iv = 31'($urandom_range(0, 20));
            endcase
        end

        r.now_sec = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
        r.now_nsec = ($urandom_range(0, 15) == 0) ? 30'($urandom)
                                                  : 30'($urandom_range(0, 999999999));
        r.dl_nsec = 30'($urandom_range(0, 999999999));
        case ($urandom_range(0, 3))
            0: r.dl_sec = r.now_sec - $urandom_range(0, 2);
            1: r.dl_sec = r.now_sec + $urandom_range(0, 1);
            2: r.dl_sec = $urandom;
            default:
            begin
                // The timer just fired on time: old deadline one interval back.
                if (r.kind == tndc_pkg::KIND_VERY_COARSE)
                    r.dl_sec = r.now_sec - 32'(r.iv);
                else
                    r.dl_sec = r.now_sec - 32'(r.iv / 1000);
                if (r.now_nsec >= 30'd5000000 && r.now_nsec < 30'd1000000000)
                    r.dl_nsec = r.now_nsec - 30'($urandom_range(0, 5000000));
                else
                    r.dl_nsec = r.now_nsec;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of requests from the pending queue, separated by random
    // gaps. A request marked to drain waits until the pipeline is empty.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_deadlines.push_back(next_deadline(cur_req));
                kind_cnt[cur_req.kind]++;
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                load_next = 1'b0;
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain || expected_deadlines.size() == 0))
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= pack_request(cur_req);
                    s_axis_tuser <= cur_req.kind;
                    load_next = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                s_axis_tvalid <= load_next;
            end
        end
    end

    // Receiver back-pressure. Patterns are picked at random, so stretches of
    // full throughput alternate with light, heavy and periodic stalls.
    always @(posedge clk)
    begin
        ready_cycle++;
        if (ready_cycle % 256 == 0)
            ready_mode = stall_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            STALL_NONE:  m_axis_tready <= 1'b1;
            STALL_LIGHT: m_axis_tready <= ($urandom_range(0, 9) < 7);
            STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= ((ready_cycle % 7) < 3);
        endcase
    end

    task automatic flag_error(string msg);
        error_cnt++;
        if (error_cnt <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Monitor: every accepted response is checked against the oldest
    // outstanding deadline.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_deadlines.size() == 0)
            begin
                flag_error($sformatf("response %0d.%09d with no request outstanding",
                                     m_axis_tdata[31:0], m_axis_tdata[61:32]));
            end
            else
            begin
                if (expected_deadlines[0].sec != m_axis_tdata[31:0] ||
                    expected_deadlines[0].nsec != m_axis_tdata[61:32])
                    flag_error($sformatf("deadline %0d: expected %0d.%09d, got %0d.%09d",
                                         checked_cnt, expected_deadlines[0].sec,
                                         expected_deadlines[0].nsec,
                                         m_axis_tdata[31:0], m_axis_tdata[61:32]));
                void'(expected_deadlines.pop_front());
                checked_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed corners, then random timers, then drain and report.
    // ------------------------------------------------------------------
    initial
    begin
        timer_req_t r;

        // Precise: zero and full-scale intervals, seconds wrap, deadline in
        // the past, nanosecond fields beyond one second.
        add_req(tndc_pkg::KIND_PRECISE, 31'd0, 32'd0, 30'd0, 32'd0, 30'd0);
        add_req(tndc_pkg::KIND_PRECISE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 30'd999999999,
                32'd0, 30'd0);
        add_req(tndc_pkg::KIND_PRECISE, 31'd1000, 32'd100, 30'd0, 32'd5000, 30'd500000000);
        add_req(tndc_pkg::KIND_PRECISE, 31'd1, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
                32'hFFFF_FFFF, 30'h3FFF_FFFF);

        // Coarse: every rounding rule, from the short intervals with no slack
        // up to the whole-second snaps.
        add_req(tndc_pkg::KIND_COARSE, 31'd7, 32'd10, 30'd123456789, 32'd10, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd30, 32'd20, 30'd17300000, 32'd20, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd60, 32'd30, 30'd13000000, 32'd30, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd25, 32'd40, 30'd412000000, 32'd40, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd50, 32'd50, 30'd611000000, 32'd50, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd75, 32'd60, 30'd288000000, 32'd60, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd100, 32'd70, 30'd237000000, 32'd70, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd200, 32'd80, 30'd391000000, 32'd80, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd250, 32'd90, 30'd119000000, 32'd90, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd150, 32'd95, 30'd463000000, 32'd95, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd123, 32'd99, 30'd555000000, 32'd99, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd500, 32'd110, 30'd180000000, 32'd110, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd5000, 32'd120, 30'd480000000, 32'd120, 30'd0);
        add_req(tndc_pkg::KIND_COARSE, 31'd40000, 32'hFFFF_FFD0, 30'd930000000,
                32'hFFFF_FFD0, 30'd0);
        // Snapping backwards lands before the current time, so one more interval follows.
        add_req(tndc_pkg::KIND_COARSE, 31'd2000, 32'd5, 30'd630000000, 32'd7, 30'd620000000);
        add_req(tndc_pkg::KIND_COARSE, 31'h7FFF_FFFF, 32'd1234, 30'd999999999,
                32'd1234, 30'd999999999);

        // Very coarse: ahead, behind, seconds wrap, full-scale interval.
        add_req(tndc_pkg::KIND_VERY_COARSE, 31'd3, 32'd500, 30'd250000000, 32'd501, 30'd0);
        add_req(tndc_pkg::KIND_VERY_COARSE, 31'd3, 32'd10, 30'd999999999, 32'd400, 30'd7);
        add_req(tndc_pkg::KIND_VERY_COARSE, 31'd5, 32'hFFFF_FFFE, 30'd1, 32'd10,
                30'h3FFF_FFFF);
        add_req(tndc_pkg::KIND_VERY_COARSE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
                32'hFFFF_FFFF, 30'd0);

        // Undefined kind with nanoseconds out of range.
        add_req(KIND_UNDEFINED, 31'h5555_5555, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
                32'd77, 30'd5);

        // Random part; every few hundred requests the driver lets the
        // pipeline empty completely before it carries on.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            r = build_random_req();
            r.drain = (i % DRAIN_EVERY == 0);
            pending_reqs.push_back(r);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_deadlines.size() != 0)
            @(posedge clk);
        // Watch a little longer for stray responses.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d timers: %0d precise, %0d coarse, %0d very coarse, %0d undefined kind.",
                 accepted_cnt, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3]);
        $display("Compared %0d deadlines, %0d errors.", checked_cnt, error_cnt);
        if (error_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Timeout with %0d deadlines outstanding.", expected_deadlines.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

[timer_next_deadline_coarsening.f]
rtl/core/tndc_pkg.sv
rtl/core/tndc_prep.sv
rtl/core/tndc_advance.sv
rtl/core/tndc_snap.sv
rtl/core/timer_next_deadline_coarsening.sv
test/tb_top.sv
